// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the core RTL.
// Every check is clocked on clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define CHK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// When the trigger is seen, the result must hold in the next cycle.
`define CHK_NEXT(lbl, trig, res, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (res)) else $error(msg);

`endif

// ----- rtl/core/bets_pkg.sv -----
// ----------------------------------------------------------------------------
// bets_pkg
// Shared widths, register indexes and types for the beam time step core.
// ----------------------------------------------------------------------------
package bets_pkg;

   localparam int NODES_MAX = 64;
   localparam int NODES_MIN = 5;
   localparam int ADDR_W    = $clog2(NODES_MAX);

   localparam int MUL_X_W = 41;
   localparam int MUL_Y_W = 20;
   localparam int PROD_W  = MUL_X_W + MUL_Y_W + 1;

   localparam logic [2:0] CSR_LOAD_GAIN  = 3'd0;
   localparam logic [2:0] CSR_MASS_GAIN  = 3'd1;
   localparam logic [2:0] CSR_DAMP_GAIN  = 3'd2;
   localparam logic [2:0] CSR_STIFF_GAIN = 3'd3;
   localparam logic [2:0] CSR_NODES      = 3'd4;

   localparam logic CMD_RUN   = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // one request to the shared multiplier: signed operand times unsigned slice
   typedef struct packed {
      logic signed [MUL_X_W-1:0] x;
      logic [MUL_Y_W-1:0]        y;
   } mul_req_type;

endpackage

// ----- rtl/core/beam_explicit_time_step_core.sv -----
// Flow: a run command first steps the beam, then streams out every node
//   in turn, each item held until the sink takes it.
// Throughput: one command at a time; the shared multiplier (six uses per
//   inner node) and the one-port node stores set the per-node time.
// Reset: control and configuration registers go to their defaults, both node
//   stores read as zero through cleared valid bits; no item is emitted.
// ----------------------------------------------------------------------------
// beam_explicit_time_step_core
// Explicit damped clamped-free beam stepping with a shared multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module beam_explicit_time_step_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // load[31:0], step_count[47:32]
   input  logic         req_tuser,   // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // node_index[5:0], displacement[37:6], zero pad
   output logic         rsp_tlast,
   output logic         rsp_tuser,   // saturated
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [39:0]  csr_wdata
);
   import bets_pkg::*;

   // sequencer states
   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_RD   = 5'd1;
   localparam logic [4:0] ST_LD   = 5'd2;
   localparam logic [4:0] ST_PRE  = 5'd3;
   localparam logic [4:0] ST_M0   = 5'd4;
   localparam logic [4:0] ST_M1   = 5'd5;
   localparam logic [4:0] ST_M2   = 5'd6;
   localparam logic [4:0] ST_M3   = 5'd7;
   localparam logic [4:0] ST_FIN  = 5'd8;
   localparam logic [4:0] ST_WR   = 5'd9;
   localparam logic [4:0] ST_ORD  = 5'd10;
   localparam logic [4:0] ST_OLD  = 5'd11;
   localparam logic [4:0] ST_OWT  = 5'd12;

   // term being built on the multiplier
   localparam logic [1:0] T_LOAD  = 2'd0;
   localparam logic [1:0] T_MASS  = 2'd1;
   localparam logic [1:0] T_DAMP  = 2'd2;
   localparam logic [1:0] T_STIFF = 2'd3;

   localparam int SUM_W = 44;
   localparam int ACC_W = 80;
   localparam int IDX_W = ADDR_W + 1;

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
      if (v > SUM_W'(64'sd2147483647))       return 32'sh7FFFFFFF;
      else if (v < -SUM_W'(64'sd2147483648)) return 32'sh80000000;
      else                                   return v[31:0];
   endfunction

   function automatic logic is_sat(input logic signed [SUM_W-1:0] v);
      return (v > SUM_W'(64'sd2147483647)) || (v < -SUM_W'(64'sd2147483648));
   endfunction

   // configuration registers
   logic [39:0] load_gain_ff;
   logic [31:0] mass_gain_ff, damp_gain_ff, stiff_gain_ff;
   logic [6:0]  nodes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_gain_ff  <= '0;
         mass_gain_ff  <= '0;
         damp_gain_ff  <= '0;
         stiff_gain_ff <= '0;
         nodes_ff      <= 7'd32;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LOAD_GAIN:  load_gain_ff  <= csr_wdata;
            CSR_MASS_GAIN:  mass_gain_ff  <= csr_wdata[31:0];
            CSR_DAMP_GAIN:  damp_gain_ff  <= csr_wdata[31:0];
            CSR_STIFF_GAIN: stiff_gain_ff <= csr_wdata[31:0];
            CSR_NODES:      nodes_ff      <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // control state
   logic [4:0]       state_ff, state_in;
   logic [1:0]       tsel_ff, tsel_in;
   logic [IDX_W:0]   fidx_ff, fidx_in;     // fetch index, node i = fidx - 2
   logic [IDX_W-1:0] oidx_ff, oidx_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic [15:0]      steps_ff, steps_in;
   logic             sat_ff, sat_in;
   logic [NODES_MAX-1:0] cur_vld_ff, cur_vld_in, prev_vld_ff, prev_vld_in;
   logic             rsp_vld_ff, rsp_vld_in;

   // datapath registers
   logic signed [31:0]       load_ff, load_in;
   logic signed [SUM_W-1:0]  load_term_ff, load_term_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [31:0]       wnd_ff [5];
   logic signed [31:0]       wnd_in [5];
   logic signed [31:0]       p_ff, p_in;
   logic signed [31:0]       new_ff, new_in;
   logic signed [31:0]       h1_ff, h1_in, h2_ff, h2_in;
   logic signed [MUL_X_W-1:0] xm_ff, xm_in, xd_ff, xd_in, xs_ff, xs_in;
   logic [39:0]              rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_sat_ff, rsp_sat_in;

   // node stores
   logic signed [31:0] cur_mem  [NODES_MAX];
   logic signed [31:0] prev_mem [NODES_MAX];
   logic signed [31:0] cur_rd_ff, prev_rd_ff;
   logic               cur_rv_ff, prev_rv_ff;
   logic [ADDR_W-1:0]  cur_raddr, prev_raddr, waddr;
   logic               mem_we;
   logic signed [31:0] cur_q, prev_q;
   logic [IDX_W:0]     node_i;

   assign node_i     = fidx_ff - (IDX_W+1)'(2);
   assign cur_raddr  = (state_ff == ST_ORD) ? oidx_ff[ADDR_W-1:0] : fidx_ff[ADDR_W-1:0];
   assign prev_raddr = node_i[ADDR_W-1:0];
   assign waddr      = node_i[ADDR_W-1:0];
   assign mem_we     = (state_ff == ST_WR);
   assign cur_q      = cur_rv_ff  ? cur_rd_ff  : 32'sd0;
   assign prev_q     = prev_rv_ff ? prev_rd_ff : 32'sd0;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cur_mem[waddr]  <= new_ff;
         prev_mem[waddr] <= wnd_ff[2];
      end
      cur_rd_ff  <= cur_mem[cur_raddr];
      prev_rd_ff <= prev_mem[prev_raddr];
      cur_rv_ff  <= cur_vld_ff[cur_raddr];
      prev_rv_ff <= prev_vld_ff[prev_raddr];
   end

   // shared multiplier
   mul_req_type              mul_req;
   logic signed [PROD_W-1:0] prod;
   logic signed [MUL_X_W-1:0] mul_x;
   logic [MUL_Y_W-1:0]       y_lo, y_hi;

   always_comb begin
      case (tsel_ff)
         T_LOAD: begin
            mul_x = MUL_X_W'(load_ff);
            y_lo  = load_gain_ff[19:0];
            y_hi  = load_gain_ff[39:20];
         end
         T_MASS: begin
            mul_x = xm_ff;
            y_lo  = mass_gain_ff[19:0];
            y_hi  = MUL_Y_W'(mass_gain_ff[31:20]);
         end
         T_DAMP: begin
            mul_x = xd_ff;
            y_lo  = damp_gain_ff[19:0];
            y_hi  = MUL_Y_W'(damp_gain_ff[31:20]);
         end
         default: begin
            mul_x = xs_ff;
            y_lo  = stiff_gain_ff[19:0];
            y_hi  = MUL_Y_W'(stiff_gain_ff[31:20]);
         end
      endcase
      mul_req.x = mul_x;
      mul_req.y = (state_ff == ST_M1) ? y_hi : y_lo;
   end

   bets_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   // floor of the full product by 2^32 for the load, 2^30 for the gains
   logic signed [SUM_W-1:0] term;
   assign term = (tsel_ff == T_LOAD) ? SUM_W'(acc_ff >>> 32) : SUM_W'(acc_ff >>> 30);

   // free-end extrapolation from the last two inner results
   logic signed [SUM_W-1:0] fe_a, fe_b;
   assign fe_a = (SUM_W'(h1_ff) <<< 1) - SUM_W'(h2_ff);
   assign fe_b = (SUM_W'(h1_ff) <<< 1) + SUM_W'(h1_ff) - (SUM_W'(h2_ff) <<< 1);

   logic [6:0] n_clamp;
   assign n_clamp = (nodes_ff < 7'(NODES_MIN)) ? 7'(NODES_MIN) :
                    (nodes_ff > 7'(NODES_MAX)) ? 7'(NODES_MAX) : nodes_ff;

   logic req_acc, rsp_acc;
   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      state_in     = state_ff;
      tsel_in      = tsel_ff;
      fidx_in      = fidx_ff;
      oidx_in      = oidx_ff;
      n_in         = n_ff;
      steps_in     = steps_ff;
      sat_in       = sat_ff;
      cur_vld_in   = cur_vld_ff;
      prev_vld_in  = prev_vld_ff;
      rsp_vld_in   = rsp_vld_ff;
      load_in      = load_ff;
      load_term_in = load_term_ff;
      sum_in       = sum_ff;
      acc_in       = acc_ff;
      wnd_in       = wnd_ff;
      p_in         = p_ff;
      new_in       = new_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      xm_in        = xm_ff;
      xd_in        = xd_ff;
      xs_in        = xs_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_sat_in   = rsp_sat_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == CMD_CLEAR) begin
                  // drop both stores at once
                  cur_vld_in  = '0;
                  prev_vld_in = '0;
               end else begin
                  load_in  = req_tdata[31:0];
                  steps_in = req_tdata[47:32];
                  n_in     = n_clamp;
                  sat_in   = 1'b0;
                  tsel_in  = T_LOAD;
                  state_in = ST_M0;
               end
            end
         end
         ST_RD: state_in = ST_LD;
         ST_LD: begin
            // advance the stencil window by one node
            wnd_in[0] = wnd_ff[1];
            wnd_in[1] = wnd_ff[2];
            wnd_in[2] = wnd_ff[3];
            wnd_in[3] = wnd_ff[4];
            wnd_in[4] = cur_q;
            p_in      = prev_q;
            if (fidx_ff < (IDX_W+1)'(2)) begin
               fidx_in  = fidx_ff + 1'b1;
               state_in = ST_RD;
            end else if (node_i < (IDX_W+1)'(2)) begin
               new_in   = 32'sd0;
               state_in = ST_WR;
            end else if (node_i + (IDX_W+1)'(3) <= (IDX_W+1)'(n_ff)) begin
               state_in = ST_PRE;
            end else if (node_i + (IDX_W+1)'(2) == (IDX_W+1)'(n_ff)) begin
               new_in   = sat32(fe_a);
               sat_in   = sat_ff || is_sat(fe_a);
               state_in = ST_WR;
            end else begin
               new_in   = sat32(fe_b);
               sat_in   = sat_ff || is_sat(fe_b);
               state_in = ST_WR;
            end
         end
         ST_PRE: begin
            xm_in = (MUL_X_W'(wnd_ff[2]) <<< 1) - MUL_X_W'(p_ff);
            xd_in = MUL_X_W'(p_ff);
            xs_in = MUL_X_W'(wnd_ff[0]) - (MUL_X_W'(wnd_ff[1]) <<< 2)
                  + (MUL_X_W'(wnd_ff[2]) <<< 2) + (MUL_X_W'(wnd_ff[2]) <<< 1)
                  - (MUL_X_W'(wnd_ff[3]) <<< 2) + MUL_X_W'(wnd_ff[4]);
            sum_in   = load_term_ff;
            tsel_in  = T_MASS;
            state_in = ST_M0;
         end
         ST_M0: state_in = ST_M1;
         ST_M1: begin
            acc_in   = ACC_W'(prod);
            state_in = ST_M2;
         end
         ST_M2: begin
            acc_in   = acc_ff + (ACC_W'(prod) <<< 20);
            state_in = ST_M3;
         end
         ST_M3: begin
            case (tsel_ff)
               T_LOAD: begin
                  load_term_in = term;
                  if (steps_ff == 16'd0) begin
                     oidx_in  = '0;
                     state_in = ST_ORD;
                  end else begin
                     fidx_in  = '0;
                     state_in = ST_RD;
                  end
               end
               T_MASS: begin
                  sum_in   = sum_ff + term;
                  tsel_in  = T_DAMP;
                  state_in = ST_M0;
               end
               T_DAMP: begin
                  sum_in   = sum_ff + term;
                  tsel_in  = T_STIFF;
                  state_in = ST_M0;
               end
               default: begin
                  sum_in   = sum_ff - term;
                  state_in = ST_FIN;
               end
            endcase
         end
         ST_FIN: begin
            new_in   = sat32(sum_ff);
            sat_in   = sat_ff || is_sat(sum_ff);
            state_in = ST_WR;
         end
         ST_WR: begin
            cur_vld_in[waddr]  = 1'b1;
            prev_vld_in[waddr] = 1'b1;
            // hold history of inner results for the free end
            if (node_i + (IDX_W+1)'(2) < (IDX_W+1)'(n_ff)) begin
               h2_in = h1_ff;
               h1_in = new_ff;
            end
            if (node_i + (IDX_W+1)'(1) == (IDX_W+1)'(n_ff)) begin
               fidx_in = '0;
               if (steps_ff == 16'd1) begin
                  oidx_in  = '0;
                  state_in = ST_ORD;
               end else begin
                  steps_in = steps_ff - 16'd1;
                  state_in = ST_RD;
               end
            end else begin
               fidx_in  = fidx_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_ORD: state_in = ST_OLD;
         ST_OLD: begin
            rsp_data_in = {2'b00, cur_q, oidx_ff[ADDR_W-1:0]};
            rsp_last_in = (oidx_ff + 1'b1 == n_ff);
            rsp_sat_in  = sat_ff;
            rsp_vld_in  = 1'b1;
            state_in    = ST_OWT;
         end
         ST_OWT: begin
            if (rsp_acc) begin
               rsp_vld_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  oidx_in  = oidx_ff + 1'b1;
                  state_in = ST_ORD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         tsel_ff     <= T_LOAD;
         fidx_ff     <= '0;
         oidx_ff     <= '0;
         n_ff        <= IDX_W'(NODES_MIN);
         steps_ff    <= '0;
         sat_ff      <= 1'b0;
         cur_vld_ff  <= '0;
         prev_vld_ff <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         tsel_ff     <= tsel_in;
         fidx_ff     <= fidx_in;
         oidx_ff     <= oidx_in;
         n_ff        <= n_in;
         steps_ff    <= steps_in;
         sat_ff      <= sat_in;
         cur_vld_ff  <= cur_vld_in;
         prev_vld_ff <= prev_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      load_ff      <= load_in;
      load_term_ff <= load_term_in;
      sum_ff       <= sum_in;
      acc_ff       <= acc_in;
      wnd_ff       <= wnd_in;
      p_ff         <= p_in;
      new_ff       <= new_in;
      h1_ff        <= h1_in;
      h2_ff        <= h2_in;
      xm_ff        <= xm_in;
      xd_ff        <= xd_in;
      xs_ff        <= xs_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_sat_ff;

   `CHK_ALWAYS(a_no_take_while_send, !(req_tready && rsp_tvalid), "input taken while sending")
   `CHK_ALWAYS(a_last_at_end, !(rsp_tvalid && rsp_tlast) || (oidx_ff + 1'b1 == n_ff), "tlast off the final node")
   `CHK_NEXT(a_clear_drops, req_acc && (req_tuser == CMD_CLEAR), (cur_vld_ff == '0) && (prev_vld_ff == '0), "clear left valid entries")

endmodule

// ----- rtl/core/bets_mul.sv -----
// ----------------------------------------------------------------------------
// bets_mul
// Registered signed by unsigned multiplier, shared by every gain term.
// ----------------------------------------------------------------------------
module bets_mul (
   input  logic                                clock,
   input  bets_pkg::mul_req_type               mul_req,
   output logic signed [bets_pkg::PROD_W-1:0]  prod
);
   import bets_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_req.x) * PROD_W'($signed({1'b0, mul_req.y}));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- verif/tb_beam_explicit_time_step_core.sv -----
// ----------------------------------------------------------------------------
// tb_beam_explicit_time_step_core
// Self-checking bench for the beam time step core. Commands go in as stream
// items in bursts. A cycle-free predictor of the beam state works out every
// node displacement that a run command must stream back. The sink stalls on
// its own pattern. Each result item is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_beam_explicit_time_step_core;
   import bets_pkg::*;

   localparam int STALL_LIMIT = 100000;
   localparam int SETTLE      = 100;

   typedef struct {
      logic        cmd;
      logic [31:0] load;
      logic [15:0] steps;
   } beam_cmd_type;

   typedef struct {
      logic [5:0]  node;
      logic [31:0] disp;
      logic        last;
      logic        sat;
   } node_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [39:0] csr_wdata;

   beam_explicit_time_step_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // predictor copy of the registers and both node stores
   logic [39:0]        load_gain_q;
   logic [31:0]        mass_gain_q, damp_gain_q, stiff_gain_q;
   logic [6:0]         nodes_q;
   logic signed [31:0] disp_now [NODES_MAX];
   logic signed [31:0] disp_old [NODES_MAX];
   bit                 step_sat;

   beam_cmd_type    pending_cmds[$];
   node_result_type expected_nodes[$];
   beam_cmd_type    next_cmd;
   node_result_type got, want;
   int              burst_left, gap_left, ready_phase, ready_mode, idle_cycles;
   int              errors;
   int              cmds_queued = 0;
   int              cmds_taken  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // floor(x * g / 2^sh), exact in 128 bits
   function automatic longint scaled(input longint x, input logic [39:0] g, input int sh);
      logic signed [127:0] prod;
      logic signed [127:0] gain;
      prod = x;
      gain = {88'd0, g};
      prod = prod * gain;
      return longint'(prod >>> sh);
   endfunction

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) begin
         step_sat = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         step_sat = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // advance the beam for one accepted command and queue its node items
   task automatic advance_beam(input beam_cmd_type c);
      int n;
      longint load_term, cv, pv, d4, sum, a, b;
      logic signed [31:0] nxt [NODES_MAX];
      node_result_type r;
      if (c.cmd == CMD_CLEAR) begin
         for (int i = 0; i < NODES_MAX; i++) begin
            disp_now[i] = '0;
            disp_old[i] = '0;
         end
         return;
      end
      n = nodes_q;
      if (n < NODES_MIN) n = NODES_MIN;
      if (n > NODES_MAX) n = NODES_MAX;
      step_sat = 1'b0;
      load_term = scaled(longint'($signed(c.load)), load_gain_q, 32);
      for (int s = 0; s < c.steps; s++) begin
         nxt[0] = '0;
         nxt[1] = '0;
         for (int i = 2; i + 2 < n; i++) begin
            cv = disp_now[i];
            pv = disp_old[i];
            d4 = longint'(disp_now[i-2]) - 4 * longint'(disp_now[i-1]) + 6 * cv
               - 4 * longint'(disp_now[i+1]) + longint'(disp_now[i+2]);
            sum = load_term + scaled(2 * cv - pv, {8'd0, mass_gain_q}, 30)
                + scaled(pv, {8'd0, damp_gain_q}, 30)
                - scaled(d4, {8'd0, stiff_gain_q}, 30);
            nxt[i] = clip32(sum);
         end
         // free end follows from the last two inner nodes
         a = nxt[n-3];
         b = nxt[n-4];
         nxt[n-2] = clip32(2 * a - b);
         nxt[n-1] = clip32(3 * a - 2 * b);
         for (int i = 0; i < n; i++) begin
            disp_old[i] = disp_now[i];
            disp_now[i] = nxt[i];
         end
      end
      for (int i = 0; i < n; i++) begin
         r.node = i[5:0];
         r.disp = disp_now[i];
         r.last = (i == n - 1);
         r.sat  = step_sat;
         expected_nodes.push_back(r);
      end
   endtask

   // driver: bursts of items with random gaps, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= CMD_RUN;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_beam('{req_tuser, req_tdata[31:0], req_tdata[47:32]});
            cmds_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               next_cmd   = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_cmd.cmd;
               req_tdata  <= {next_cmd.steps, next_cmd.load};
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 8);
                  gap_left   <= ($urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // sink: switch between always ready, coin flip and mostly stalled
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         ready_phase <= 0;
         ready_mode  <= 0;
      end else begin
         if (ready_phase == 0) begin
            ready_phase <= $urandom_range(50, 300);
            ready_mode  <= $urandom_range(0, 2);
         end else begin
            ready_phase <= ready_phase - 1;
         end
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom % 4 == 0);
         endcase
      end
   end

   // monitor: compare every accepted node item with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.node = rsp_tdata[5:0];
         got.disp = rsp_tdata[37:6];
         got.last = rsp_tlast;
         got.sat  = rsp_tuser;
         if (expected_nodes.size() == 0) begin
            $display("%0t: unexpected node item node=%0d disp=%h", $time, got.node, got.disp);
            errors++;
         end else begin
            want = expected_nodes.pop_front();
            if (got.node !== want.node || got.disp !== want.disp ||
                got.last !== want.last || got.sat !== want.sat) begin
               $display("%0t: mismatch expected node=%0d disp=%h last=%b sat=%b",
                        $time, want.node, want.disp, want.last, want.sat);
               $display("%0t:          actual   node=%0d disp=%h last=%b sat=%b",
                        $time, got.node, got.disp, got.last, got.sat);
               errors++;
            end
         end
      end
   end

   // watchdog: end the run if neither side moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("beam_explicit_time_step_core test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_cmd(input logic cmd, input logic [31:0] load, input logic [15:0] steps);
      pending_cmds.push_back('{cmd, load, steps});
      cmds_queued++;
   endtask

   // hold until every queued item is taken and answered, then let the core settle
   task automatic drain();
      do @(posedge clock);
      while (cmds_taken != cmds_queued || expected_nodes.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [39:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_LOAD_GAIN:  load_gain_q  = val;
         CSR_MASS_GAIN:  mass_gain_q  = val[31:0];
         CSR_DAMP_GAIN:  damp_gain_q  = val[31:0];
         CSR_STIFF_GAIN: stiff_gain_q = val[31:0];
         CSR_NODES:      nodes_q      = val[6:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all(input logic [39:0] lg, input logic [39:0] mg, input logic [39:0] dg,
                            input logic [39:0] sg, input logic [39:0] nodes);
      write_reg(CSR_LOAD_GAIN, lg);
      write_reg(CSR_MASS_GAIN, mg);
      write_reg(CSR_DAMP_GAIN, dg);
      write_reg(CSR_STIFF_GAIN, sg);
      write_reg(CSR_NODES, nodes);
      end_writes();
   endtask

   int n_eff, r;
   logic [15:0] steps;

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      errors       = 0;
      idle_cycles  = 0;
      load_gain_q  = '0;
      mass_gain_q  = '0;
      damp_gain_q  = '0;
      stiff_gain_q = '0;
      nodes_q      = 7'd32;
      for (int i = 0; i < NODES_MAX; i++) begin
         disp_now[i] = '0;
         disp_old[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // default registers: all gains zero, beam stays flat
      push_cmd(CMD_RUN, 32'h7FFF_FFFF, 16'd1);
      push_cmd(CMD_RUN, 32'h0001_0000, 16'd0);
      drain();

      // full load gain on the shortest beam: drive into saturation both ways
      write_all(40'hFF_FFFF_FFFF, 40'h4000_0000, 40'h0, 40'h0, 40'd5);
      push_cmd(CMD_RUN, 32'h7FFF_FFFF, 16'd1);
      push_cmd(CMD_RUN, 32'h8000_0000, 16'd2);
      push_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
      push_cmd(CMD_RUN, 32'h0000_0000, 16'd0);
      push_cmd(CMD_RUN, 32'h0001_0000, 16'd1);
      drain();

      // realistic gains, node count below the floor acts as five
      write_all(40'h00_0100_0000, 40'h3FF0_0000, 40'h0010_0000, 40'h1000_0000, 40'd0);
      push_cmd(CMD_RUN, 32'h0001_0000, 16'd3);
      push_cmd(CMD_RUN, 32'hFFFF_0000, 16'd2);
      drain();

      // full length beam, then above the ceiling, then a short one
      write_reg(CSR_NODES, 40'd64);
      end_writes();
      push_cmd(CMD_RUN, 32'h0004_0000, 16'd2);
      drain();
      write_reg(CSR_NODES, 40'd127);
      end_writes();
      push_cmd(CMD_RUN, 32'h0004_0000, 16'd1);
      drain();
      write_reg(CSR_NODES, 40'd8);
      end_writes();
      push_cmd(CMD_RUN, 32'hFFF0_0000, 16'd2);
      drain();
      // nodes past the short beam must have kept their old values
      write_reg(CSR_NODES, 40'd64);
      end_writes();
      push_cmd(CMD_RUN, 32'h0000_0000, 16'd0);
      drain();

      // extreme stiffness and damping, no mass term
      write_all(40'h00_0000_1000, 40'h0, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 40'd6);
      push_cmd(CMD_RUN, 32'h0100_0000, 16'd4);
      push_cmd(CMD_CLEAR, 32'h0, 16'h8000);
      push_cmd(CMD_RUN, 32'h8000_0001, 16'd3);
      drain();

      // random phases: new registers, then a run of mostly well-formed commands
      for (int ph = 0; ph < 13; ph++) begin
         r = $urandom_range(0, 5);
         if (r == 0) begin
            write_all(40'({$urandom, $urandom}), 40'({$urandom, $urandom}),
                      40'({$urandom, $urandom}), 40'({$urandom, $urandom}),
                      40'($urandom_range(0, 127)));
         end else begin
            write_all({8'd0, $urandom} >> $urandom_range(0, 16),
                      40'h4000_0000 - 40'($urandom_range(0, 32'h0200_0000)),
                      40'($urandom_range(0, 32'h0100_0000)),
                      40'($urandom_range(0, 32'h1000_0000)),
                      (r == 1) ? 40'($urandom_range(0, 127)) : 40'($urandom_range(5, 16)));
         end
         n_eff = nodes_q < NODES_MIN ? NODES_MIN : (nodes_q > NODES_MAX ? NODES_MAX : nodes_q);
         for (int k = 0; k < 35; k++) begin
            if ($urandom % 8 == 0) begin
               push_cmd(CMD_CLEAR, $urandom, 16'($urandom));
            end else begin
               if (n_eff >= 40) steps = 16'($urandom_range(0, 2));
               else if ($urandom % 10 < 8) steps = 16'($urandom_range(0, 3));
               else steps = 16'($urandom_range(4, 24));
               push_cmd(CMD_RUN, $urandom, steps);
            end
         end
         drain();
      end

      if (errors == 0) begin
         $display("beam_explicit_time_step_core test passed");
      end else begin
         $display("beam_explicit_time_step_core test failed");
      end
      $finish;
   end

endmodule
